[design/fdep_pkg.sv]
// shared types and constants for the fat directory entry parser
package fdep_pkg;

  // entry geometry
  localparam int POS_W = 5;

  localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
  localparam logic [POS_W-1:0] POS_EXT_START = 5'd8;
  localparam logic [POS_W-1:0] POS_ATTR      = 5'd11;
  localparam logic [POS_W-1:0] POS_CLUS_HI_L = 5'd20;
  localparam logic [POS_W-1:0] POS_CLUS_HI_H = 5'd21;
  localparam logic [POS_W-1:0] POS_CLUS_LO_L = 5'd26;
  localparam logic [POS_W-1:0] POS_CLUS_LO_H = 5'd27;
  localparam logic [POS_W-1:0] POS_SIZE      = 5'd28;
  localparam logic [POS_W-1:0] POS_LAST      = 5'd31;

  // marker bytes
  localparam logic [7:0] BYTE_END        = 8'h00;
  localparam logic [7:0] BYTE_DELETED    = 8'hE5;
  localparam logic [7:0] BYTE_SPACE      = 8'h20;
  localparam logic [7:0] ATTR_LONG_NAME  = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME_BIT = 8'h08;

  localparam int OUT_TDATA_W = 168;

  typedef struct packed {
    logic       scan_start;
    logic       sector_start;
    logic [7:0] dir_byte;
  } dir_item_t;

  // packed so that base_name sits in the lowest bits
  typedef struct packed {
    logic [4:0]  table_slot;
    logic [31:0] file_size;
    logic [31:0] start_cluster;
    logic [1:0]  ext_len;
    logic [23:0] ext_name;
    logic [3:0]  base_len;
    logic [63:0] base_name;
  } dir_result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

[design/fdep_in_stage.sv]
// input register of the directory byte stream
module fdep_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdep_pkg::dir_item_t in_item,
  input  logic                advance,
  output logic                item_valid,
  output fdep_pkg::dir_item_t item
);

  // slot frees when empty or when the held byte moves on
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[design/fdep_entry_core.sv]
// entry state and single-pass decode of one directory byte
module fdep_entry_core #(
  parameter int MAX_FILES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fdep_pkg::stage_ctl_t  ctl,
  input  fdep_pkg::dir_item_t   item,
  output logic                  res_valid,
  output fdep_pkg::dir_result_t res
);

  localparam int FCW = $clog2(MAX_FILES + 1);

  logic [fdep_pkg::POS_W-1:0] byte_position;
  logic                       sector_ended;
  logic                       entry_skipped;
  logic [63:0]                base_bytes;
  logic [3:0]                 base_count;
  logic                       base_stopped;
  logic [23:0]                ext_bytes;
  logic [1:0]                 ext_count;
  logic                       ext_stopped;
  logic [15:0]                cluster_high;
  logic [15:0]                cluster_low;
  logic [31:0]                size_bytes;
  logic [FCW-1:0]             file_count;

  logic [fdep_pkg::POS_W-1:0] p;
  logic                       first;
  logic [7:0]                 b;
  logic                       fire;
  logic [FCW-1:0]             fc_eff;

  logic                       sector_ended_next;
  logic                       entry_skipped_next;
  logic [63:0]                base_bytes_next;
  logic [3:0]                 base_count_next;
  logic                       base_stopped_next;
  logic [23:0]                ext_bytes_next;
  logic [1:0]                 ext_count_next;
  logic                       ext_stopped_next;
  logic [15:0]                cluster_high_next;
  logic [15:0]                cluster_low_next;
  logic [31:0]                size_bytes_next;
  logic [FCW-1:0]             file_count_next;

  assign fire   = ctl.valid && ctl.advance;
  assign b      = item.dir_byte;
  assign p      = item.sector_start ? fdep_pkg::POS_FIRST : byte_position;
  assign first  = (p == fdep_pkg::POS_FIRST);
  assign fc_eff = item.scan_start ? '0 : file_count;

  always_comb begin
    // entry byte 0 restarts the per-entry fields
    sector_ended_next  = item.sector_start ? 1'b0 : sector_ended;
    if (first && b == fdep_pkg::BYTE_END) begin
      sector_ended_next = 1'b1;
    end
    entry_skipped_next = first ? (b == fdep_pkg::BYTE_DELETED) : entry_skipped;
    base_bytes_next    = first ? '0 : base_bytes;
    base_count_next    = first ? '0 : base_count;
    base_stopped_next  = first ? 1'b0 : base_stopped;
    ext_bytes_next     = first ? '0 : ext_bytes;
    ext_count_next     = first ? '0 : ext_count;
    ext_stopped_next   = first ? 1'b0 : ext_stopped;
    cluster_high_next  = first ? '0 : cluster_high;
    cluster_low_next   = first ? '0 : cluster_low;
    size_bytes_next    = first ? '0 : size_bytes;

    if (p < fdep_pkg::POS_EXT_START) begin
      base_bytes_next = {base_bytes_next[55:0], b};
      if (b == fdep_pkg::BYTE_SPACE) begin
        base_stopped_next = 1'b1;
      end else if (!base_stopped_next) begin
        base_count_next = base_count_next + 4'd1;
      end
    end else if (p < fdep_pkg::POS_ATTR) begin
      ext_bytes_next = {ext_bytes_next[15:0], b};
      if (b == fdep_pkg::BYTE_SPACE) begin
        ext_stopped_next = 1'b1;
      end else if (!ext_stopped_next) begin
        ext_count_next = ext_count_next + 2'd1;
      end
    end else if (p == fdep_pkg::POS_ATTR) begin
      // long-name entries and volume labels are dropped
      if (b == fdep_pkg::ATTR_LONG_NAME || (b & fdep_pkg::ATTR_VOLUME_BIT) != 8'h00) begin
        entry_skipped_next = 1'b1;
      end
    end else if (p == fdep_pkg::POS_CLUS_HI_L) begin
      cluster_high_next[7:0] = b;
    end else if (p == fdep_pkg::POS_CLUS_HI_H) begin
      cluster_high_next[15:8] = b;
    end else if (p == fdep_pkg::POS_CLUS_LO_L) begin
      cluster_low_next[7:0] = b;
    end else if (p == fdep_pkg::POS_CLUS_LO_H) begin
      cluster_low_next[15:8] = b;
    end else if (p >= fdep_pkg::POS_SIZE) begin
      case (p[1:0])
        2'd0:    size_bytes_next[7:0]   = b;
        2'd1:    size_bytes_next[15:8]  = b;
        2'd2:    size_bytes_next[23:16] = b;
        default: size_bytes_next[31:24] = b;
      endcase
    end
  end

  assign res_valid = fire && (p == fdep_pkg::POS_LAST) && !sector_ended_next &&
                     !entry_skipped_next && (fc_eff < FCW'(MAX_FILES));

  assign file_count_next = res_valid ? fc_eff + 1'b1 : fc_eff;

  always_comb begin
    res.base_name     = base_bytes_next;
    res.base_len      = base_count_next;
    res.ext_name      = ext_bytes_next;
    res.ext_len       = ext_count_next;
    res.start_cluster = {cluster_high_next, cluster_low_next};
    res.file_size     = size_bytes_next;
    res.table_slot    = 5'(fc_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      sector_ended  <= 1'b0;
      entry_skipped <= 1'b0;
      base_bytes    <= '0;
      base_count    <= '0;
      base_stopped  <= 1'b0;
      ext_bytes     <= '0;
      ext_count     <= '0;
      ext_stopped   <= 1'b0;
      cluster_high  <= '0;
      cluster_low   <= '0;
      size_bytes    <= '0;
      file_count    <= '0;
    end else if (fire) begin
      byte_position <= p + 1'b1;
      sector_ended  <= sector_ended_next;
      entry_skipped <= entry_skipped_next;
      base_bytes    <= base_bytes_next;
      base_count    <= base_count_next;
      base_stopped  <= base_stopped_next;
      ext_bytes     <= ext_bytes_next;
      ext_count     <= ext_count_next;
      ext_stopped   <= ext_stopped_next;
      cluster_high  <= cluster_high_next;
      cluster_low   <= cluster_low_next;
      size_bytes    <= size_bytes_next;
      file_count    <= file_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    file_count <= FCW'(MAX_FILES))
    else $error("file count above table size");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (p == fdep_pkg::POS_LAST))
    else $error("result outside entry last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> file_count == FCW'($past(fc_eff) + 1'b1))
    else $error("file count did not step after result");

  a_ended_quiet: assert property (@(posedge clk) disable iff (rst)
    (sector_ended && !item.sector_start) |-> !res_valid)
    else $error("result after end marker");

endmodule

[design/fdep_out_stage.sv]
// result register toward the output stream
module fdep_out_stage (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 res_valid,
  input  fdep_pkg::dir_result_t                res,
  output logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fdep_pkg::OUT_TDATA_W-1:0]     out_data
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
    if (advance && res_valid) begin
      out_data <= fdep_pkg::OUT_TDATA_W'(res);
    end
  end

endmodule

[design/fat_dir_entry_parser.sv]
// top level of the fat directory entry parser
// Takes a FAT directory sector as a byte stream, one byte per cycle when not
// stalled, and cuts it into 32-byte entries. Each byte is decoded in a single
// pass between an input register and a result register, so the block sustains
// one request per cycle while the output side is ready; the byte that completes
// an entry (byte 31) is held in the input register, and its result is then
// registered in the result register. The output register is the only stall
// point: when a result waits, the input holds its byte and new requests pause.
// An entry that starts with 0x00 ends parsing for the rest of the sector;
// deleted (0xE5), long-name (attribute 0x0F) and volume-label (attribute bit
// 0x08) entries give no result. At most MAX_FILES results come per scan.
module fat_dir_entry_parser #(
  parameter int MAX_FILES = 32
) (
  input  logic         clk,
  input  logic         rst,
  // byte stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // dir_byte
  input  logic [1:0]   s_axis_tuser,   // sector_start, scan_start
  // entry results out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // base_name[63:0], base_len[67:64], ext_name[91:68], ext_len[93:92],
  // start_cluster[125:94], file_size[157:126], table_slot[162:158], zero pad
  output logic [167:0] m_axis_tdata
);

  fdep_pkg::dir_item_t   in_item;
  fdep_pkg::dir_item_t   item;
  fdep_pkg::dir_result_t res;
  fdep_pkg::stage_ctl_t  ctl;
  logic                  item_valid;
  logic                  advance;
  logic                  res_valid;

  // pack the request fields
  assign in_item.dir_byte     = s_axis_tdata;
  assign in_item.sector_start = s_axis_tuser[0];
  assign in_item.scan_start   = s_axis_tuser[1];

  // byte register, released whenever the result register can move
  fdep_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign ctl.valid   = item_valid;
  assign ctl.advance = advance;

  // entry state, filters and field capture
  fdep_entry_core #(
    .MAX_FILES (MAX_FILES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  fdep_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
